// ===== hdl/fbpa_pkg.sv =====
// shared types, codes and constants of the fixed block pool allocator
package fbpa_pkg;

    localparam int ALIGN_BYTES_DEF = 16;
    localparam int MAX_BLOCKS_DEF  = 256;

    localparam int OP_W     = 2;
    localparam int CNT16_W  = 16;
    localparam int OFFS_W   = 20;
    localparam int STAT_W   = 3;
    localparam int FREE_W   = 9;
    localparam int PAYLD_W  = 13;
    localparam int POOL_W   = 20;
    localparam int CFG_W    = 20;
    // block size: 13-bit payload rounded up to an alignment of at most 64, plus a header of at most 64
    localparam int BSZ_W    = 14;
    localparam int PROD_W   = 32;
    localparam int REM_W    = 16;

    localparam logic [PAYLD_W-1:0] PAYLD_RESET = PAYLD_W'(16);
    localparam logic [POOL_W-1:0]  POOL_RESET  = '0;

    typedef enum logic [OP_W-1:0] {
        OP_RESERVE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK           = 3'd0,
        STAT_EMPTY        = 3'd1,
        STAT_BAD_SIZE     = 3'd2,
        STAT_BAD_OFFSET   = 3'd3,
        STAT_ALREADY_FREE = 3'd4
    } status_t;

    typedef enum logic {
        CFG_PAYLOAD_BYTES = 1'b0,
        CFG_POOL_BYTES    = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [CNT16_W-1:0] num_elems;
        logic [CNT16_W-1:0] elem_bytes;
        logic [OFFS_W-1:0]  release_offset;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFFS_W-1:0] payload_offset;
        logic [FREE_W-1:0] free_blocks;
    } rsp_t;

    // command to the shared multiply / divide unit
    typedef struct packed {
        logic              start;
        logic              is_div;
        logic [OFFS_W-1:0] opa;
        logic [REM_W-1:0]  opb;
    } md_cmd_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] res;
        logic [REM_W-1:0]  rem;
    } md_rsp_t;

endpackage

// ===== hdl/fbpa_muldiv.sv =====
// shared bit-serial unit: shift-add multiply and restoring divide
module fbpa_muldiv
    import fbpa_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  md_cmd_t cmd,
    output md_rsp_t rsp
);

    localparam int STEP_W = $clog2(OFFS_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              div_reg, div_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] x_reg, x_next;
    logic [REM_W-1:0]  y_reg, y_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [REM_W:0]    trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        trial     = {acc_reg[REM_W-1:0], x_reg[OFFS_W-1]} - {1'b0, y_reg};
        if (cmd.start) begin
            busy_next = 1'b1;
            div_next  = cmd.is_div;
            step_next = cmd.is_div ? STEP_W'(OFFS_W) : STEP_W'(CNT16_W);
            x_next    = cmd.is_div ? PROD_W'(cmd.opa) : PROD_W'(cmd.opa[CNT16_W-1:0]);
            y_next    = cmd.opb;
            acc_next  = '0;
        end else if (busy_reg) begin
            if (div_reg) begin
                // quotient bits enter at the bottom as dividend bits leave the top
                if (!trial[REM_W]) begin
                    acc_next = PROD_W'(trial[REM_W-1:0]);
                end else begin
                    acc_next = PROD_W'({acc_reg[REM_W-2:0], x_reg[OFFS_W-1]});
                end
                x_next = {x_reg[PROD_W-2:0], ~trial[REM_W]};
            end else begin
                if (y_reg[0]) begin
                    acc_next = acc_reg + x_reg;
                end
                x_next = {x_reg[PROD_W-2:0], 1'b0};
                y_next = {1'b0, y_reg[REM_W-1:1]};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg  <= div_next;
        step_reg <= step_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = div_reg ? PROD_W'(x_reg[OFFS_W-1:0]) : acc_reg;
    assign rsp.rem  = acc_reg[REM_W-1:0];

endmodule

// ===== hdl/fixed_block_pool_allocator.sv =====
// fixed block pool allocator: free list of equal blocks with reserve, release and clear
//
//  port group | direction | handshake         | payload
//  s_*        | in        | s_valid / s_ready | s_data  (req_t)
//  m_*        | out       | m_valid / m_ready | m_data  (rsp_t)
//  cfg_*      | in        | cfg_we            | cfg_index, cfg_wdata
//
// one request at a time; one bit-serial multiply/divide unit sets the latency:
// a reserve runs two 16-step multiplies, a release one 20-step divide, a clear one
// 20-step divide and then builds the list one block at a time; a request rejected before
// any arithmetic skips the unit, a reserve too big skips the second multiply and a bad
// release offset is found after the divide. aresetn is synchronous; after reset the
// pool is empty until a clear. s_ready stays low from acceptance until the response is
// loaded in the output register, which waits while the previous response lacks m_ready
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int ALIGN_BYTES = ALIGN_BYTES_DEF,
    parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  req_t              s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rsp_t              m_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_BLOCKS);
    localparam logic [BSZ_W-1:0]  ALIGN_MASK = BSZ_W'(ALIGN_BYTES - 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_MUL_SIZE = 7'b0000010,
        S_MUL_OFFS = 7'b0000100,
        S_DIV      = 7'b0001000,
        S_FREE_CHK = 7'b0010000,
        S_CLR_WALK = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [PAYLD_W-1:0] payload_reg;
    logic [POOL_W-1:0]  pool_reg;

    req_t              req_reg, req_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] count_reg, count_next;
    logic [LINK_W-1:0] total_reg, total_next;
    logic [LINK_W-1:0] walk_reg, walk_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [OFFS_W-1:0] poff_reg, poff_next;
    logic              m_valid_reg, m_valid_next;
    rsp_t              m_data_reg, m_data_next;

    logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
    logic              free_mem [MAX_BLOCKS];
    logic [LINK_W-1:0] link_q_reg;
    logic              free_q_reg;

    logic              link_we, link_re;
    logic [IDX_W-1:0]  link_waddr, link_raddr;
    logic [LINK_W-1:0] link_wdata;
    logic              free_we, free_re;
    logic [IDX_W-1:0]  free_waddr, free_raddr;
    logic              free_wdata;

    logic [BSZ_W-1:0]  slot_bytes;
    logic [BSZ_W-1:0]  block_bytes;
    logic [OFFS_W-1:0] hdr_offs;
    logic [OFFS_W-1:0] quo;

    md_cmd_t md_cmd;
    md_rsp_t md_rsp;

    fbpa_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (md_cmd),
        .rsp     (md_rsp)
    );

    // slot is the payload rounded up to the alignment; the header comes in front
    assign slot_bytes  = (BSZ_W'(payload_reg) + ALIGN_MASK) & ~ALIGN_MASK;
    assign block_bytes = slot_bytes + BSZ_W'(ALIGN_BYTES);
    assign hdr_offs    = req_reg.release_offset - OFFS_W'(ALIGN_BYTES);
    assign quo         = md_rsp.res[OFFS_W-1:0];

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        walk_next    = walk_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        poff_next    = poff_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        md_cmd       = '0;
        link_we      = 1'b0;
        link_waddr   = '0;
        link_wdata   = head_reg;
        link_re      = 1'b0;
        link_raddr   = head_reg[IDX_W-1:0];
        free_we      = 1'b0;
        free_waddr   = '0;
        free_wdata   = 1'b0;
        free_re      = 1'b0;
        free_raddr   = quo[IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next    = s_data;
                    status_next = STAT_OK;
                    poff_next   = '0;
                    state_next  = S_DONE;
                    case (s_data.operation)
                        OP_RESERVE: begin
                            if (count_reg == '0 || head_reg >= LINK_NULL) begin
                                status_next = STAT_EMPTY;
                            end else if (s_data.num_elems == '0 || s_data.elem_bytes == '0) begin
                                status_next = STAT_BAD_SIZE;
                            end else begin
                                md_cmd.start  = 1'b1;
                                md_cmd.is_div = 1'b0;
                                md_cmd.opa    = OFFS_W'(s_data.num_elems);
                                md_cmd.opb    = s_data.elem_bytes;
                                link_re       = 1'b1;
                                state_next    = S_MUL_SIZE;
                            end
                        end
                        OP_RELEASE: begin
                            if (s_data.release_offset < OFFS_W'(ALIGN_BYTES)) begin
                                status_next = STAT_BAD_OFFSET;
                            end else begin
                                md_cmd.start  = 1'b1;
                                md_cmd.is_div = 1'b1;
                                md_cmd.opa    = s_data.release_offset - OFFS_W'(ALIGN_BYTES);
                                md_cmd.opb    = REM_W'(block_bytes);
                                state_next    = S_DIV;
                            end
                        end
                        OP_CLEAR: begin
                            md_cmd.start  = 1'b1;
                            md_cmd.is_div = 1'b1;
                            md_cmd.opa    = OFFS_W'(pool_reg);
                            md_cmd.opb    = REM_W'(block_bytes);
                            state_next    = S_DIV;
                        end
                        default: begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_MUL_SIZE: begin
                if (md_rsp.done) begin
                    // slot is aligned, so comparing the unrounded size is enough
                    if (md_rsp.res > PROD_W'(slot_bytes)) begin
                        status_next = STAT_BAD_SIZE;
                        state_next  = S_DONE;
                    end else begin
                        idx_next   = head_reg[IDX_W-1:0];
                        head_next  = (link_q_reg > LINK_NULL) ? LINK_NULL : link_q_reg;
                        count_next = count_reg - LINK_W'(1);
                        free_we    = 1'b1;
                        free_waddr = head_reg[IDX_W-1:0];
                        free_wdata = 1'b0;
                        md_cmd.start  = 1'b1;
                        md_cmd.is_div = 1'b0;
                        md_cmd.opa    = OFFS_W'(head_reg[IDX_W-1:0]);
                        md_cmd.opb    = REM_W'(block_bytes);
                        state_next = S_MUL_OFFS;
                    end
                end
            end
            S_MUL_OFFS: begin
                if (md_rsp.done) begin
                    poff_next   = md_rsp.res[OFFS_W-1:0] + OFFS_W'(ALIGN_BYTES);
                    status_next = STAT_OK;
                    state_next  = S_DONE;
                end
            end
            S_DIV: begin
                if (md_rsp.done) begin
                    if (req_reg.operation == OP_CLEAR) begin
                        if (quo > OFFS_W'(MAX_BLOCKS)) begin
                            total_next = LINK_NULL;
                            count_next = LINK_NULL;
                        end else begin
                            total_next = quo[LINK_W-1:0];
                            count_next = quo[LINK_W-1:0];
                        end
                        head_next  = LINK_NULL;
                        walk_next  = '0;
                        state_next = S_CLR_WALK;
                    end else if (md_rsp.rem != '0 || hdr_offs >= pool_reg ||
                                 quo >= OFFS_W'(total_reg)) begin
                        status_next = STAT_BAD_OFFSET;
                        state_next  = S_DONE;
                    end else begin
                        idx_next   = quo[IDX_W-1:0];
                        free_re    = 1'b1;
                        state_next = S_FREE_CHK;
                    end
                end
            end
            S_FREE_CHK: begin
                if (free_q_reg) begin
                    status_next = STAT_ALREADY_FREE;
                end else begin
                    link_we     = 1'b1;
                    link_waddr  = idx_reg;
                    link_wdata  = head_reg;
                    free_we     = 1'b1;
                    free_waddr  = idx_reg;
                    free_wdata  = 1'b1;
                    head_next   = LINK_W'(idx_reg);
                    count_next  = count_reg + LINK_W'(1);
                    status_next = STAT_OK;
                end
                state_next = S_DONE;
            end
            S_CLR_WALK: begin
                // push blocks in ascending order so block 0 ends at the tail
                if (walk_reg < total_reg) begin
                    link_we    = 1'b1;
                    link_waddr = walk_reg[IDX_W-1:0];
                    link_wdata = head_reg;
                    free_we    = 1'b1;
                    free_waddr = walk_reg[IDX_W-1:0];
                    free_wdata = 1'b1;
                    head_next  = walk_reg;
                    walk_next  = walk_reg + LINK_W'(1);
                end else begin
                    status_next = STAT_OK;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.status         = status_reg;
                    m_data_next.payload_offset = poff_reg;
                    m_data_next.free_blocks    = FREE_W'(count_reg);
                    state_next                 = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            payload_reg <= PAYLD_RESET;
            pool_reg    <= POOL_RESET;
            head_reg    <= LINK_NULL;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PAYLOAD_BYTES: payload_reg <= cfg_wdata[PAYLD_W-1:0];
                    CFG_POOL_BYTES:    pool_reg    <= cfg_wdata[POOL_W-1:0];
                    default:           pool_reg    <= pool_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        walk_reg   <= walk_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        poff_reg   <= poff_next;
        m_data_reg <= m_data_next;
    end

    // link and free-flag stores, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re) begin
            link_q_reg <= link_mem[link_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (free_we) begin
            free_mem[free_waddr] <= free_wdata;
        end
        if (free_re) begin
            free_q_reg <= free_mem[free_raddr];
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/fbpa_checker.sv =====
// port checker for the fixed block pool allocator and its bind
module fbpa_port_checker
    import fbpa_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input rsp_t m_data
);

    // a stalled response holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("response changed while stalled");

    // one request in flight: ready drops right after a request is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after a request");

    // status codes above already free are never produced
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= STAT_ALREADY_FREE)
        else $error("unknown status code");

    // an offset is returned only with a good status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STAT_OK |-> m_data.payload_offset == '0)
        else $error("offset returned with an error status");

endmodule

bind fixed_block_pool_allocator fbpa_port_checker u_fbpa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== sim/fbpa_checker.sv =====
// response checker for the pool allocator: keeps its own free list, predicts and compares
`timescale 1ns / 1ps
module fbpa_checker
    import fbpa_pkg::*;
#(
    parameter int ALIGN_BYTES = ALIGN_BYTES_DEF,
    parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  req_t             s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  rsp_t             m_data,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int               mismatches,
    output int               awaited
);

    logic [PAYLD_W-1:0] cfg_payload;
    logic [POOL_W-1:0]  cfg_pool;
    int unsigned        link_of   [MAX_BLOCKS];
    bit                 free_flag [MAX_BLOCKS];
    int unsigned        top_blk;
    int unsigned        n_free;
    int unsigned        n_blocks;
    int                 rsp_seen;
    rsp_t               due_rsp [$];

    function automatic longint unsigned round_align(input longint unsigned v);
        return (v + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
    endfunction

    // applies one request to the tracked pool and returns the response it should give
    function automatic rsp_t pool_step(input req_t r);
        rsp_t            rsp;
        longint unsigned slot;
        longint unsigned bsz;
        longint unsigned hdr;
        longint unsigned idx;
        longint unsigned n;
        int unsigned     blk;
        rsp  = '0;
        slot = round_align(64'(cfg_payload));
        bsz  = slot + ALIGN_BYTES;
        case (r.operation)
            OP_RESERVE: begin
                if (n_free == 0 || top_blk >= MAX_BLOCKS) begin
                    rsp.status = STAT_EMPTY;
                end else if (r.num_elems == 0 || r.elem_bytes == 0 ||
                             round_align(64'(r.num_elems) * 64'(r.elem_bytes)) > slot) begin
                    rsp.status = STAT_BAD_SIZE;
                end else begin
                    blk            = top_blk;
                    top_blk        = (link_of[blk] > MAX_BLOCKS) ? MAX_BLOCKS : link_of[blk];
                    free_flag[blk] = 1'b0;
                    n_free--;
                    rsp.payload_offset = OFFS_W'(blk * bsz + ALIGN_BYTES);
                end
            end
            OP_RELEASE: begin
                if (r.release_offset < ALIGN_BYTES) begin
                    rsp.status = STAT_BAD_OFFSET;
                end else begin
                    hdr = 64'(r.release_offset) - 64'(ALIGN_BYTES);
                    idx = hdr / bsz;
                    if (hdr % bsz != 0 || hdr >= cfg_pool || idx >= n_blocks ||
                        idx >= MAX_BLOCKS) begin
                        rsp.status = STAT_BAD_OFFSET;
                    end else if (free_flag[idx]) begin
                        rsp.status = STAT_ALREADY_FREE;
                    end else begin
                        link_of[idx]   = top_blk;
                        free_flag[idx] = 1'b1;
                        top_blk        = 32'(idx);
                        n_free++;
                    end
                end
            end
            OP_CLEAR: begin
                // highest block ends up on top, block 0 at the tail
                n = cfg_pool / bsz;
                if (n > MAX_BLOCKS) n = MAX_BLOCKS;
                top_blk = MAX_BLOCKS;
                for (int i = 0; i < MAX_BLOCKS; i++) begin
                    free_flag[i] = (i < n);
                    if (i < n) begin
                        link_of[i] = top_blk;
                        top_blk    = i;
                    end
                end
                n_blocks = 32'(n);
                n_free   = 32'(n);
            end
            default: begin
            end
        endcase
        rsp.free_blocks = FREE_W'(n_free);
        return rsp;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] response %0d: %s", $time, rsp_seen, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        rsp_t want;
        if (!aresetn) begin
            cfg_payload = PAYLD_RESET;
            cfg_pool    = POOL_RESET;
            foreach (free_flag[i]) free_flag[i] = 1'b0;
            top_blk    = MAX_BLOCKS;
            n_free     = 0;
            n_blocks   = 0;
            rsp_seen   = 0;
            mismatches = 0;
            due_rsp.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (due_rsp.size() == 0) begin
                    report_mismatch($sformatf("unexpected, status %0d offset %0d free %0d",
                                              m_data.status, m_data.payload_offset,
                                              m_data.free_blocks));
                end else begin
                    want = due_rsp.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_data.status, want.status));
                    if (m_data.payload_offset !== want.payload_offset)
                        report_mismatch($sformatf("payload_offset %0d, expected %0d",
                                                  m_data.payload_offset, want.payload_offset));
                    if (m_data.free_blocks !== want.free_blocks)
                        report_mismatch($sformatf("free_blocks %0d, expected %0d",
                                                  m_data.free_blocks, want.free_blocks));
                end
                rsp_seen++;
            end
            if (s_valid && s_ready) due_rsp.push_back(pool_step(s_data));
            if (cfg_we) begin
                if (cfg_index == CFG_PAYLOAD_BYTES) cfg_payload = cfg_wdata[PAYLD_W-1:0];
                else cfg_pool = cfg_wdata[POOL_W-1:0];
            end
        end
        awaited = due_rsp.size();
    end

endmodule

// ===== sim/tb_fixed_block_pool_allocator.sv =====
// testbench top for the pool allocator: clock, reset, request stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_fixed_block_pool_allocator
    import fbpa_pkg::*;
();

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int STUCK_LIMIT  = 3000;
    localparam int PHASE_ITEMS  = 54;
    localparam int ALIGN        = ALIGN_BYTES_DEF;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    req_t             s_data;
    logic             m_valid;
    logic             m_ready;
    rsp_t             m_data;
    logic             cfg_we;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    int                mismatches;
    int                awaited;
    int                sent_cnt = 0;
    int                got_cnt  = 0;
    int                phases_run = 0;
    int                op_sent [4];
    int                status_seen [8];
    logic              burst;
    int unsigned       cur_payload;
    int unsigned       cur_pool;
    logic [OFFS_W-1:0] held_offs [$];
    logic [OFFS_W-1:0] freed_offs [$];

    always #HALF_PERIOD aclk = ~aclk;

    fixed_block_pool_allocator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fbpa_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    // handshake counters; reserved offsets are kept so later releases can hit live blocks
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sent_cnt <= sent_cnt + 1;
        if (aresetn && m_valid && m_ready) begin
            got_cnt <= got_cnt + 1;
            status_seen[m_data.status]++;
            if (m_data.status == STAT_OK && m_data.payload_offset != '0)
                held_offs.push_back(m_data.payload_offset);
        end
    end

    function automatic int unsigned slot_of(input int unsigned payload);
        return (payload + ALIGN - 1) / ALIGN * ALIGN;
    endfunction

    function automatic req_t make_req(input op_t op, input int unsigned cnt,
                                      input int unsigned nbytes, input int unsigned offs);
        req_t r;
        r.operation      = op;
        r.num_elems      = CNT16_W'(cnt);
        r.elem_bytes     = CNT16_W'(nbytes);
        r.release_offset = OFFS_W'(offs);
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_req(input req_t r);
        int gap;
        int mark;
        gap = burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        op_sent[r.operation]++;
        if (r.operation == OP_CLEAR) begin
            held_offs.delete();
            freed_offs.delete();
        end
        mark = sent_cnt;
        do @(negedge aclk); while (sent_cnt == mark);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (awaited != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(val);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        if (idx == CFG_PAYLOAD_BYTES) cur_payload = val;
        else cur_pool = val;
    endtask

    task automatic run_phase(input int unsigned payload, input int unsigned pool,
                             input bit rebuild, input bit no_idle);
        req_t        r;
        int unsigned roll;
        int unsigned pick;
        int unsigned slot;
        int unsigned bsz;
        int unsigned cnt;
        int          idx;
        drain();
        write_reg(CFG_PAYLOAD_BYTES, payload);
        write_reg(CFG_POOL_BYTES, pool);
        burst = no_idle;
        slot  = slot_of(cur_payload);
        bsz   = slot + ALIGN;
        if (rebuild) send_req(make_req(OP_CLEAR, 0, 0, 0));
        repeat (PHASE_ITEMS) begin
            r.operation      = OP_NONE;
            r.num_elems      = CNT16_W'($urandom);
            r.elem_bytes     = CNT16_W'($urandom);
            r.release_offset = OFFS_W'($urandom);
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            if (roll < 47) begin
                r.operation = OP_RESERVE;
                if (pick < 70) begin
                    cnt          = $urandom_range(1, 4);
                    r.num_elems  = CNT16_W'(cnt);
                    r.elem_bytes = CNT16_W'($urandom_range(1, slot / cnt));
                end else if (pick < 80) begin
                    // just past the slot
                    r.num_elems  = CNT16_W'(1);
                    r.elem_bytes = CNT16_W'(slot + $urandom_range(1, ALIGN));
                end else if (pick < 86) begin
                    r.num_elems = '0;
                end else if (pick < 92) begin
                    r.elem_bytes = '0;
                end
            end else if (roll < 89) begin
                r.operation = OP_RELEASE;
                if (pick < 65 && held_offs.size() > 0) begin
                    idx              = $urandom_range(0, held_offs.size() - 1);
                    r.release_offset = held_offs[idx];
                    freed_offs.push_back(held_offs[idx]);
                    held_offs.delete(idx);
                    if (freed_offs.size() > 16) void'(freed_offs.pop_front());
                end else if (pick < 75 && freed_offs.size() > 0) begin
                    r.release_offset = freed_offs[$urandom_range(0, freed_offs.size() - 1)];
                end else if (pick < 85) begin
                    // aligned header, block index may run past the pool
                    r.release_offset = OFFS_W'($urandom_range(0, pool / bsz + 3) * bsz + ALIGN);
                end else if (pick < 92) begin
                    r.release_offset = OFFS_W'($urandom_range(0, pool / bsz) * bsz + ALIGN
                                               + $urandom_range(1, bsz - 1));
                end else if (pick < 95) begin
                    r.release_offset = OFFS_W'($urandom_range(0, ALIGN - 1));
                end
            end else if (roll < 94) begin
                r.operation = OP_CLEAR;
            end
            send_req(r);
        end
        phases_run++;
    endtask

    // response side: waits for a response, stalls a random number of cycles, then takes it
    initial begin : sink
        int stall;
        int mark;
        m_ready = 1'b0;
        forever begin
            do @(negedge aclk); while (!m_valid);
            stall = burst ? 0 : $urandom_range(0, 14);
            repeat (stall) @(negedge aclk);
            m_ready <= 1'b1;
            mark = got_cnt;
            do @(negedge aclk); while (got_cnt == mark);
            m_ready <= 1'b0;
        end
    end

    initial begin : watchdog
        int quiet;
        int last_sent;
        int last_got;
        quiet     = 0;
        last_sent = 0;
        last_got  = 0;
        while (quiet < STUCK_LIMIT) begin
            @(negedge aclk);
            if (sent_cnt != last_sent || got_cnt != last_got) quiet = 0;
            else quiet++;
            last_sent = sent_cnt;
            last_got  = got_cnt;
        end
        $display("fixed_block_pool_allocator verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned rnd_payload;
        int unsigned rnd_block;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_PAYLOAD_BYTES;
        cfg_wdata   = '0;
        burst       = 1'b0;
        cur_payload = 32'(PAYLD_RESET);
        cur_pool    = 32'(POOL_RESET);
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // out of reset the pool is empty and has no size
        send_req(make_req(OP_RESERVE, 1, 1, 0));
        send_req(make_req(OP_RELEASE, 0, 0, ALIGN));
        send_req(make_req(OP_NONE, 16'hFFFF, 16'hFFFF, 20'hFFFFF));
        send_req(make_req(OP_CLEAR, 0, 0, 0));
        drain();

        // 32-byte blocks, pool holds exactly five
        write_reg(CFG_PAYLOAD_BYTES, 16);
        write_reg(CFG_POOL_BYTES, 160);
        send_req(make_req(OP_CLEAR, 0, 0, 0));
        send_req(make_req(OP_RESERVE, 0, 4, 0));
        send_req(make_req(OP_RESERVE, 4, 0, 0));
        send_req(make_req(OP_RESERVE, 16'hFFFF, 16'hFFFF, 0));
        send_req(make_req(OP_RESERVE, 1, 16, 0));
        send_req(make_req(OP_RESERVE, 17, 1, 0));
        send_req(make_req(OP_RESERVE, 2, 8, 0));
        send_req(make_req(OP_RELEASE, 0, 0, ALIGN - 1));
        send_req(make_req(OP_RELEASE, 0, 0, 145));
        send_req(make_req(OP_RELEASE, 0, 0, 20'hFFFFF));
        send_req(make_req(OP_RELEASE, 0, 0, 112));
        send_req(make_req(OP_RELEASE, 0, 0, 112));
        // block 0 is the tail of the list and still free
        send_req(make_req(OP_RELEASE, 0, 0, ALIGN));
        send_req(make_req(OP_RELEASE, 0, 0, 176));
        repeat (4) send_req(make_req(OP_RESERVE, 1, 1, 0));
        send_req(make_req(OP_RESERVE, 1, 1, 0));
        send_req(make_req(OP_RELEASE, 0, 0, ALIGN));
        send_req(make_req(OP_NONE, 0, 0, 0));

        run_phase(1, 20'hFFFFF, 1'b1, 1'b0);
        run_phase(4096, 20'hFFFFF, 1'b1, 1'b0);
        run_phase(100, 896, 1'b1, 1'b1);
        // block size changes under a live list
        run_phase(48, 896, 1'b0, 1'b0);
        run_phase(33, 0, 1'b1, 1'b0);
        rnd_payload = $urandom_range(1, 4096);
        rnd_block   = slot_of(rnd_payload) + ALIGN;
        run_phase(rnd_payload, rnd_block * $urandom_range(0, 40)
                               + $urandom_range(0, rnd_block - 1), 1'b1, 1'b0);
        run_phase(16, 1000, 1'b1, 1'b1);
        run_phase($urandom_range(1, 4096), $urandom_range(0, 20'hFFFFF), 1'b1, 1'b0);

        drain();
        repeat (40) @(negedge aclk);
        $display("ran %0d requests, %0d pool setups: %0d reserve, %0d release, %0d clear, %0d unused",
                 sent_cnt, phases_run + 2, op_sent[OP_RESERVE], op_sent[OP_RELEASE],
                 op_sent[OP_CLEAR], op_sent[OP_NONE]);
        $display("responses: %0d ok, %0d empty, %0d bad size, %0d bad offset, %0d already free",
                 status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_BAD_SIZE],
                 status_seen[STAT_BAD_OFFSET], status_seen[STAT_ALREADY_FREE]);
        if (mismatches == 0 && awaited == 0) begin
            $display("fixed_block_pool_allocator verification clean");
        end else begin
            $display("fixed_block_pool_allocator verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/fbpa_pkg.sv
hdl/fbpa_muldiv.sv
hdl/fixed_block_pool_allocator.sv
hdl/fbpa_checker.sv
sim/fbpa_checker.sv
sim/tb_fixed_block_pool_allocator.sv
